// ===== hdl/cpf_pkg.sv =====
`default_nettype none

package cpf_pkg;

   localparam int MAX_NODES = 32;

   localparam int ID_W      = 5;
   localparam int CNT_W     = 6;
   localparam int WORD_W    = 32;
   localparam int TICK_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_OK      = 4'b0010,
      PH_SUCCESS = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   // input action codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_MSG   = 2'd2;

   // received message commands
   localparam logic [1:0] CMD_OK      = 2'd0;
   localparam logic [1:0] CMD_SUCCESS = 2'd1;

   // outgoing message kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_PROPOSE = 2'd1;
   localparam logic [1:0] KIND_EXECUTE = 2'd2;
   localparam logic [1:0] KIND_GIVE_UP = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TICKET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VALUE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TIMEOUT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERALL_TIMEOUT = 3'd5;

   typedef struct packed {
      logic [ID_W-1:0]          own_id;
      logic [CNT_W-1:0]         node_count;
      logic [WORD_W-1:0]        start_ticket;
      logic signed [WORD_W-1:0] initial_value;
      logic [TICK_W-1:0]        phase_timeout;
      logic [TICK_W-1:0]        overall_timeout;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [1:0]               msg_command;
      logic [ID_W-1:0]          msg_sender;
      logic [WORD_W-1:0]        msg_ticket;
      logic signed [WORD_W-1:0] msg_value;
   } item_type;

   typedef struct packed {
      logic [1:0]               send_kind;
      logic [ID_W-1:0]          from_node;
      logic [WORD_W-1:0]        dest_mask;
      logic [WORD_W-1:0]        send_ticket;
      logic signed [WORD_W-1:0] send_value;
   } result_type;

   typedef struct packed {
      phase_type                phase;
      logic [WORD_W-1:0]        ticket;
      logic [WORD_W-1:0]        best_ticket;
      logic signed [WORD_W-1:0] chosen_value;
      logic [CNT_W-1:0]         ok_count;
      logic [CNT_W-1:0]         success_count;
      logic [WORD_W-1:0]        responder_mask;
      logic [TICK_W-1:0]        phase_ticks;
      logic [TICK_W-1:0]        total_ticks;
   } state_type;

   // Nodes 0..n-1 are members, n limited to MAX_NODES and the mask width.
   function automatic logic [WORD_W-1:0] member_mask(input logic [CNT_W-1:0] n);
      int                lim;
      logic [WORD_W-1:0] m;
      lim = int'(n);
      if (lim > MAX_NODES) begin
         lim = MAX_NODES;
      end
      for (int i = 0; i < WORD_W; i++) begin
         m[i] = (i < lim);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cpf_ifs.sv =====
`default_nettype none

interface cpf_req_if import cpf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               action;
   logic [1:0]               msg_command;
   logic [ID_W-1:0]          msg_sender;
   logic [WORD_W-1:0]        msg_ticket;
   logic signed [WORD_W-1:0] msg_value;

   modport source (output valid, action, msg_command, msg_sender, msg_ticket, msg_value,
                   input ready);
   modport sink   (input valid, action, msg_command, msg_sender, msg_ticket, msg_value,
                   output ready);
endinterface

interface cpf_rsp_if import cpf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               send_kind;
   logic [ID_W-1:0]          from_node;
   logic [WORD_W-1:0]        dest_mask;
   logic [WORD_W-1:0]        send_ticket;
   logic signed [WORD_W-1:0] send_value;

   modport source (output valid, send_kind, from_node, dest_mask, send_ticket, send_value,
                   input ready);
   modport sink   (input valid, send_kind, from_node, dest_mask, send_ticket, send_value,
                   output ready);
endinterface

interface cpf_csr_if import cpf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/cpf_step.sv =====
`default_nettype none

module cpf_step import cpf_pkg::*; (
   input  state_type  state,
   input  cfg_type    cfg,
   input  item_type   item,
   output state_type  state_next,
   output logic       res_valid,
   output result_type res
);

   logic [CNT_W-1:0]  half;
   logic [WORD_W-1:0] members;
   logic [CNT_W-1:0]  ok_inc;
   logic [CNT_W-1:0]  succ_inc;
   logic [TICK_W-1:0] total_inc;
   logic [TICK_W-1:0] phase_inc;
   logic [WORD_W-1:0] attempt_ticket;

   assign half    = cfg.node_count >> 1;
   assign members = member_mask(cfg.node_count);

   assign ok_inc    = (state.ok_count == CNT_MAX) ? state.ok_count : state.ok_count + 1'b1;
   assign succ_inc  = (state.success_count == CNT_MAX) ? state.success_count
                                                       : state.success_count + 1'b1;
   assign total_inc = (state.total_ticks == TICK_MAX) ? state.total_ticks
                                                      : state.total_ticks + 1'b1;
   assign phase_inc = (state.phase_ticks == TICK_MAX) ? state.phase_ticks
                                                      : state.phase_ticks + 1'b1;

   // start reloads the ticket before raising it; a phase timeout raises the current one
   assign attempt_ticket = ((item.action == ACT_START) ? cfg.start_ticket : state.ticket)
                           + 1'b1;

   always_comb begin
      state_next      = state;
      res_valid       = 1'b0;
      res.send_kind   = KIND_REQUEST;
      res.from_node   = cfg.own_id;
      res.dest_mask   = members;
      res.send_ticket = '0;
      res.send_value  = state.chosen_value;

      if (item.action == ACT_START) begin
         state_next.ticket         = attempt_ticket;
         state_next.chosen_value   = cfg.initial_value;
         state_next.total_ticks    = '0;
         state_next.phase          = PH_OK;
         state_next.ok_count       = '0;
         state_next.success_count  = '0;
         state_next.best_ticket    = '0;
         state_next.responder_mask = '0;
         state_next.phase_ticks    = '0;
         res_valid                 = 1'b1;
         res.send_ticket           = attempt_ticket;
         res.send_value            = '0;
      end else if (item.action == ACT_TICK) begin
         if (state.phase == PH_OK || state.phase == PH_SUCCESS) begin
            state_next.total_ticks = total_inc;
            state_next.phase_ticks = phase_inc;
            if (total_inc >= cfg.overall_timeout) begin
               state_next.phase = PH_DONE;
               res_valid        = 1'b1;
               res.send_kind    = KIND_GIVE_UP;
            end else if (phase_inc >= cfg.phase_timeout) begin
               state_next.ticket         = attempt_ticket;
               state_next.phase          = PH_OK;
               state_next.ok_count       = '0;
               state_next.success_count  = '0;
               state_next.best_ticket    = '0;
               state_next.responder_mask = '0;
               state_next.phase_ticks    = '0;
               res_valid                 = 1'b1;
               res.send_ticket           = attempt_ticket;
               res.send_value            = '0;
            end
         end
      end else if (item.action == ACT_MSG) begin
         if (state.phase == PH_OK && item.msg_command == CMD_OK) begin
            state_next.ok_count       = ok_inc;
            state_next.responder_mask = state.responder_mask
                                        | (WORD_W'(1) << item.msg_sender);
            if (item.msg_ticket > state.best_ticket) begin
               state_next.best_ticket  = item.msg_ticket;
               state_next.chosen_value = item.msg_value;
            end
            if (ok_inc > half) begin
               state_next.phase         = PH_SUCCESS;
               state_next.success_count = '0;
               state_next.phase_ticks   = '0;
               res_valid                = 1'b1;
               res.send_kind            = KIND_PROPOSE;
               res.dest_mask            = state_next.responder_mask;
               res.send_ticket          = state.ticket;
               res.send_value           = state_next.chosen_value;
            end
         end else if (state.phase == PH_SUCCESS && item.msg_command == CMD_SUCCESS) begin
            state_next.success_count = succ_inc;
            if (succ_inc > half) begin
               state_next.phase = PH_DONE;
               res_valid        = 1'b1;
               res.send_kind    = KIND_EXECUTE;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/consensus_proposer_fsm.sv =====
`default_nettype none

// Proposer of a three-phase consensus exchange. Each req item is a start, a
// tick or a received message; each causes at most one rsp item (ticket
// request, propose, execute or give-up). Items pass through an input
// register, combinational update logic against the proposer state, and a
// result register, so one item is taken every clock cycle unless stalled.
// The only stall comes from the result register: while a result waits there
// and rsp_ch.ready is low, the item in the input register holds and
// req_ch.ready drops. Registers are written through csr_ch (always ready);
// the user must write them only while no item is in flight, and the block
// itself does not enforce this. Index 0 own_id, 1 node_count, 2 start_ticket,
// 3 initial_value, 4 phase_timeout, 5 overall_timeout, other indexes are dropped.
module consensus_proposer_fsm import cpf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   cpf_req_if.sink    req_ch,
   cpf_rsp_if.source  rsp_ch,
   cpf_csr_if.sink    csr_ch
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   item_type   item_ff;
   logic       stage_vld_ff, stage_vld_in;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;

   state_type  step_state;
   logic       step_res_valid;
   result_type step_res;

   logic       req_accept;
   logic       advance;

   // The stage moves on when the result slot is free or being emptied.
   assign advance    = stage_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !stage_vld_ff || advance;
   assign req_accept = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_OWN_ID:          cfg_in.own_id          = csr_ch.data[ID_W-1:0];
            CSR_NODE_COUNT:      cfg_in.node_count      = csr_ch.data[CNT_W-1:0];
            CSR_START_TICKET:    cfg_in.start_ticket    = csr_ch.data;
            CSR_INITIAL_VALUE:   cfg_in.initial_value   = csr_ch.data;
            CSR_PHASE_TIMEOUT:   cfg_in.phase_timeout   = csr_ch.data[TICK_W-1:0];
            CSR_OVERALL_TIMEOUT: cfg_in.overall_timeout = csr_ch.data[TICK_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   cpf_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state_next (step_state),
      .res_valid  (step_res_valid),
      .res        (step_res)
   );

   // Commit the state only when the stage advances.
   assign state_in = advance ? step_state : state_ff;

   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (req_accept) begin
         stage_vld_in = 1'b1;
      end else if (advance) begin
         stage_vld_in = 1'b0;
      end
   end

   // Fill the result slot on a producing item, drop it when taken.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && step_res_valid) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id          <= '0;
         cfg_ff.node_count      <= CNT_W'(5);
         cfg_ff.start_ticket    <= '0;
         cfg_ff.initial_value   <= '0;
         cfg_ff.phase_timeout   <= TICK_W'(100);
         cfg_ff.overall_timeout <= TICK_W'(1000);
         state_ff.phase          <= PH_IDLE;
         state_ff.ticket         <= '0;
         state_ff.best_ticket    <= '0;
         state_ff.chosen_value   <= '0;
         state_ff.ok_count       <= '0;
         state_ff.success_count  <= '0;
         state_ff.responder_mask <= '0;
         state_ff.phase_ticks    <= '0;
         state_ff.total_ticks    <= '0;
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.action      <= req_ch.action;
         item_ff.msg_command <= req_ch.msg_command;
         item_ff.msg_sender  <= req_ch.msg_sender;
         item_ff.msg_ticket  <= req_ch.msg_ticket;
         item_ff.msg_value   <= req_ch.msg_value;
      end
      if (advance && step_res_valid) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.send_kind   = rsp_ff.send_kind;
   assign rsp_ch.from_node   = rsp_ff.from_node;
   assign rsp_ch.dest_mask   = rsp_ff.dest_mask;
   assign rsp_ch.send_ticket = rsp_ff.send_ticket;
   assign rsp_ch.send_value  = rsp_ff.send_value;

   // Every attempt opens with the success count cleared.
   a_ok_phase_success_clear : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_OK |-> state_ff.success_count == '0)
      else $error("success count nonzero while collecting ok replies");

   // A fresh result comes only from an item that sat in the input register.
   a_rsp_from_stage : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(stage_vld_ff))
      else $error("result appeared without an item in the stage");

   // Before the first start nothing has been counted.
   a_idle_clean : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> (state_ff.total_ticks == '0 && state_ff.ok_count == '0
                                     && state_ff.responder_mask == '0))
      else $error("idle proposer holds counts");

   // A full slot that is not taken keeps the stage from advancing.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ch.ready) |=> $stable(rsp_ff))
      else $error("waiting result overwritten");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb import cpf_pkg::*; ();

   localparam int                   WATCHDOG_LIMIT = 2000;
   localparam int                   SETTINGS_RUN   = 8;
   localparam int                   ITEMS_PER_RUN  = 230;
   localparam int                   DRAIN_CYCLES   = 6;
   // index outside the register map; the block must drop the write
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED     = 3'd7;
   // action and command codes outside the defined set
   localparam logic [1:0]           ACT_UNUSED     = 2'd3;
   localparam logic [1:0]           CMD_UNUSED     = 2'd3;

   // Shadow of the proposer: mirrors the registers and the protocol state,
   // predicts the outgoing message for each accepted item and checks it.
   class proposer_tracker;
      cfg_type    regs;
      state_type  st;
      result_type pending_sends[$];
      int         failures;
      int         mismatches;
      int         items_taken;
      int         sends_seen;
      int         kind_seen[4];

      function void clear();
         regs.own_id          = '0;
         regs.node_count      = 6'd5;
         regs.start_ticket    = '0;
         regs.initial_value   = '0;
         regs.phase_timeout   = 16'd100;
         regs.overall_timeout = 16'd1000;
         st                   = '0;
         st.phase             = PH_IDLE;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_OWN_ID:          regs.own_id          = data[ID_W-1:0];
            CSR_NODE_COUNT:      regs.node_count      = data[CNT_W-1:0];
            CSR_START_TICKET:    regs.start_ticket    = data;
            CSR_INITIAL_VALUE:   regs.initial_value   = data;
            CSR_PHASE_TIMEOUT:   regs.phase_timeout   = data[TICK_W-1:0];
            CSR_OVERALL_TIMEOUT: regs.overall_timeout = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      // members are nodes 0..n-1, capped by the node limit and the mask width
      function logic [WORD_W-1:0] members();
         int n;
         n = int'(regs.node_count);
         if (n > MAX_NODES) n = MAX_NODES;
         if (n >= WORD_W) return '1;
         return (WORD_W'(1) << n) - 1;
      endfunction

      function void queue_send(logic [1:0] kind, logic [WORD_W-1:0] mask,
                               logic [WORD_W-1:0] tk, logic signed [WORD_W-1:0] val);
         result_type r;
         r.send_kind   = kind;
         r.from_node   = regs.own_id;
         r.dest_mask   = mask;
         r.send_ticket = tk;
         r.send_value  = val;
         pending_sends.push_back(r);
      endfunction

      function void begin_attempt();
         st.ticket         = st.ticket + 1;
         st.phase          = PH_OK;
         st.ok_count       = '0;
         st.success_count  = '0;
         st.best_ticket    = '0;
         st.responder_mask = '0;
         st.phase_ticks    = '0;
         queue_send(KIND_REQUEST, members(), st.ticket, '0);
      endfunction

      function void take_item(item_type it);
         logic [CNT_W-1:0] half;
         half = regs.node_count >> 1;
         items_taken++;
         case (it.action)
            ACT_START: begin
               st.ticket       = regs.start_ticket;
               st.chosen_value = regs.initial_value;
               st.total_ticks  = '0;
               begin_attempt();
            end
            ACT_TICK: begin
               if (st.phase == PH_OK || st.phase == PH_SUCCESS) begin
                  if (st.total_ticks != TICK_MAX) st.total_ticks++;
                  if (st.phase_ticks != TICK_MAX) st.phase_ticks++;
                  // give-up beats a phase timeout on the same tick
                  if (st.total_ticks >= regs.overall_timeout) begin
                     st.phase = PH_DONE;
                     queue_send(KIND_GIVE_UP, members(), '0, st.chosen_value);
                  end else if (st.phase_ticks >= regs.phase_timeout) begin
                     begin_attempt();
                  end
               end
            end
            ACT_MSG: begin
               if (st.phase == PH_OK && it.msg_command == CMD_OK) begin
                  if (st.ok_count != CNT_MAX) st.ok_count++;
                  st.responder_mask |= WORD_W'(1) << it.msg_sender;
                  if (it.msg_ticket > st.best_ticket) begin
                     st.best_ticket  = it.msg_ticket;
                     st.chosen_value = it.msg_value;
                  end
                  if (st.ok_count > half) begin
                     st.phase         = PH_SUCCESS;
                     st.success_count = '0;
                     st.phase_ticks   = '0;
                     queue_send(KIND_PROPOSE, st.responder_mask, st.ticket, st.chosen_value);
                  end
               end else if (st.phase == PH_SUCCESS && it.msg_command == CMD_SUCCESS) begin
                  if (st.success_count != CNT_MAX) st.success_count++;
                  if (st.success_count > half) begin
                     st.phase = PH_DONE;
                     queue_send(KIND_EXECUTE, members(), '0, st.chosen_value);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void report(string what, result_type want, result_type got);
         failures++;
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
            $display("   want kind=%0d from=%0d mask=%h ticket=%h value=%0d",
                     want.send_kind, want.from_node, want.dest_mask,
                     want.send_ticket, want.send_value);
            $display("   got  kind=%0d from=%0d mask=%h ticket=%h value=%0d",
                     got.send_kind, got.from_node, got.dest_mask,
                     got.send_ticket, got.send_value);
         end
      endfunction

      function void match_send(result_type got);
         result_type want;
         sends_seen++;
         kind_seen[got.send_kind]++;
         if (pending_sends.size() == 0) begin
            report("message with nothing pending", '0, got);
            return;
         end
         want = pending_sends.pop_front();
         if (got.send_kind != want.send_kind || got.from_node != want.from_node ||
             got.dest_mask != want.dest_mask || got.send_ticket != want.send_ticket ||
             got.send_value != want.send_value) begin
            report("field differs", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   idle_cycles;

   cpf_req_if req_ch ();
   cpf_rsp_if rsp_ch ();
   cpf_csr_if csr_ch ();

   proposer_tracker track;

   consensus_proposer_fsm dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sink side: check every accepted message, stall at random unless the
   // steady stretch is on.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.send_kind   = rsp_ch.send_kind;
         got.from_node   = rsp_ch.from_node;
         got.dest_mask   = rsp_ch.dest_mask;
         got.send_ticket = rsp_ch.send_ticket;
         got.send_value  = rsp_ch.send_value;
         track.match_send(got);
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 14);
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d messages pending",
                  idle_cycles, track.pending_sends.size());
         $display("tb: errors");
         $finish;
      end
   end

   function automatic item_type make_item(logic [1:0] act, logic [1:0] cmd,
                                          logic [ID_W-1:0] snd, logic [WORD_W-1:0] tk,
                                          logic signed [WORD_W-1:0] val);
      item_type it;
      it.action      = act;
      it.msg_command = cmd;
      it.msg_sender  = snd;
      it.msg_ticket  = tk;
      it.msg_value   = val;
      return it;
   endfunction

   function automatic cfg_type cfg_of(logic [ID_W-1:0] id, logic [CNT_W-1:0] n,
                                      logic [WORD_W-1:0] st_tk, logic [WORD_W-1:0] iv,
                                      logic [TICK_W-1:0] pt, logic [TICK_W-1:0] ot);
      cfg_type c;
      c.own_id          = id;
      c.node_count      = n;
      c.start_ticket    = st_tk;
      c.initial_value   = iv;
      c.phase_timeout   = pt;
      c.overall_timeout = ot;
      return c;
   endfunction

   // Fixed corners first (widest network, single node, oversized count,
   // zero timeout), then random settings with short timeouts.
   function automatic cfg_type setting(int s);
      case (s)
         0: return cfg_of(5'd31, 6'd32, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 16'd12, 16'hFFFF);
         1: return cfg_of(5'd0, 6'd1, 32'h0, 32'h8000_0000, 16'd1, 16'd1);
         2: return cfg_of(ID_W'($urandom), 6'd63, $urandom, $urandom, 16'hFFFF, 16'd300);
         3: return cfg_of(ID_W'($urandom), 6'd2, $urandom, $urandom, 16'd0, 16'd40);
         default: return cfg_of(ID_W'($urandom), CNT_W'($urandom_range(32, 1)),
                                $urandom, $urandom,
                                TICK_W'($urandom_range(30, 2)),
                                TICK_W'($urandom_range(400, 20)));
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // Mostly replies that fit the current phase, so runs reach propose and
   // execute; the rest is restarts, ticks, wrong commands and bad actions.
   function automatic item_type next_random_item();
      int         r;
      logic [1:0] other_cmd;
      logic [1:0] stray_act;
      r         = $urandom_range(99);
      other_cmd = 2'($urandom_range(3, 2));
      stray_act = ACT_UNUSED;
      case (track.st.phase)
         PH_OK: begin
            if (r < 3)  return make_item(ACT_START, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 23) return make_item(ACT_TICK, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 80) return make_item(ACT_MSG, CMD_OK, ID_W'($urandom),
                                         pick_word(), pick_word());
            if (r < 86) return make_item(ACT_MSG, CMD_SUCCESS, ID_W'($urandom),
                                         pick_word(), $urandom);
            if (r < 92) return make_item(ACT_MSG, other_cmd, ID_W'($urandom),
                                         pick_word(), $urandom);
            if (r < 96) return make_item(stray_act, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            return make_item(ACT_MSG, CMD_OK, ID_W'($urandom), pick_word(), pick_word());
         end
         PH_SUCCESS: begin
            if (r < 3)  return make_item(ACT_START, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 23) return make_item(ACT_TICK, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 75) return make_item(ACT_MSG, CMD_SUCCESS, ID_W'($urandom),
                                         pick_word(), $urandom);
            if (r < 85) return make_item(ACT_MSG, CMD_OK, ID_W'($urandom),
                                         pick_word(), pick_word());
            if (r < 93) return make_item(ACT_MSG, other_cmd, ID_W'($urandom),
                                         pick_word(), $urandom);
            return make_item(stray_act, 2'($urandom), ID_W'($urandom), $urandom, $urandom);
         end
         default: begin
            if (r < 70) return make_item(ACT_START, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 85) return make_item(ACT_TICK, 2'($urandom), ID_W'($urandom),
                                         $urandom, $urandom);
            if (r < 95) return make_item(ACT_MSG, 2'($urandom), ID_W'($urandom),
                                         pick_word(), $urandom);
            return make_item(stray_act, 2'($urandom), ID_W'($urandom), $urandom, $urandom);
         end
      endcase
   endfunction

   // Present one item and hold it until the block takes it. Valid stays high
   // for a back-to-back item unless a one-cycle gap is inserted.
   task automatic push_item(input item_type it);
      req_ch.valid       <= 1'b1;
      req_ch.action      <= it.action;
      req_ch.msg_command <= it.msg_command;
      req_ch.msg_sender  <= it.msg_sender;
      req_ch.msg_ticket  <= it.msg_ticket;
      req_ch.msg_value   <= it.msg_value;
      do @(posedge clock); while (!req_ch.ready);
      track.take_item(it);
      if (!steady && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop valid, wait for every pending message, then let the pipeline empty
   // of items that produce nothing.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (track.pending_sends.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      track.write_reg(idx, data);
   endtask

   // Write the whole register set back to back; lead with a write to an
   // unmapped index that must change nothing.
   task automatic program_regs(input cfg_type c);
      csr_write(CSR_UNUSED, $urandom);
      csr_write(CSR_OWN_ID, WORD_W'(c.own_id));
      csr_write(CSR_NODE_COUNT, WORD_W'(c.node_count));
      csr_write(CSR_START_TICKET, c.start_ticket);
      csr_write(CSR_INITIAL_VALUE, c.initial_value);
      csr_write(CSR_PHASE_TIMEOUT, WORD_W'(c.phase_timeout));
      csr_write(CSR_OVERALL_TIMEOUT, WORD_W'(c.overall_timeout));
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      track              = new();
      track.clear();
      clock              = 1'b0;
      reset              = 1'b1;
      steady             = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_START;
      req_ch.msg_command = CMD_OK;
      req_ch.msg_sender  = '0;
      req_ch.msg_ticket  = '0;
      req_ch.msg_value   = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_OWN_ID;
      csr_ch.data        = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings (five nodes, majority three).
      // Idle-phase noise: tick, reply and unknown action are all ignored.
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd4, 32'd9, 32'sd9));
      push_item(make_item(ACT_UNUSED, CMD_UNUSED, 5'd31, '1, '1));
      push_item(make_item(ACT_START, CMD_OK, 5'd0, '0, '0));
      // wrong and unknown commands while collecting oks
      push_item(make_item(ACT_MSG, CMD_UNUSED, 5'd1, '1, '1));
      push_item(make_item(ACT_MSG, CMD_SUCCESS, 5'd2, '0, '0));
      // highest ticket wins the value; a repeat sender counts again
      push_item(make_item(ACT_MSG, CMD_OK, 5'd31, 32'hFFFF_FFFF, 32'sh8000_0000));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd31, 32'h0, 32'sh7FFF_FFFF));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd0, 32'd5, -32'sd1));
      // late ok during the accept phase is dropped
      push_item(make_item(ACT_MSG, CMD_OK, 5'd3, 32'd7, 32'sd7));
      // restart mid run, then a clean run to execute
      push_item(make_item(ACT_START, CMD_SUCCESS, 5'd0, '0, '0));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd1, 32'd10, 32'sd100));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd2, 32'd20, 32'sd200));
      push_item(make_item(ACT_MSG, CMD_OK, 5'd3, 32'd15, 32'sd150));
      push_item(make_item(ACT_MSG, CMD_SUCCESS, 5'd1, '0, '0));
      push_item(make_item(ACT_MSG, CMD_SUCCESS, 5'd2, '0, '0));
      push_item(make_item(ACT_MSG, CMD_SUCCESS, 5'd3, '0, '0));
      // finished: tick and replies are ignored
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_MSG, CMD_SUCCESS, 5'd4, '0, '0));

      // ticket wrap, and both timeouts expiring on the same tick
      wait_drained();
      program_regs(cfg_of(5'd31, 6'd1, 32'hFFFF_FFFF, 32'h8000_0000, 16'd3, 16'd3));
      push_item(make_item(ACT_START, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));

      // oversized node count saturates the mask; zero phase timeout fires at once
      wait_drained();
      program_regs(cfg_of(5'd17, 6'd40, 32'd7, 32'h1234_5678, 16'd0, 16'hFFFF));
      push_item(make_item(ACT_START, CMD_OK, 5'd0, '0, '0));
      push_item(make_item(ACT_TICK, CMD_OK, 5'd0, '0, '0));

      // Random part: one setting per stretch; one middle stretch runs with
      // no idling on either side.
      for (int s = 0; s < SETTINGS_RUN; s++) begin
         wait_drained();
         program_regs(setting(s));
         steady = (s == 5);
         for (int k = 0; k < ITEMS_PER_RUN; k++) begin
            push_item(next_random_item());
         end
      end
      steady = 1'b0;
      wait_drained();

      $display("summary: %0d items through %0d register settings, %0d messages checked",
               track.items_taken, SETTINGS_RUN + 3, track.sends_seen);
      $display("summary: request %0d, propose %0d, execute %0d, give-up %0d, failures %0d",
               track.kind_seen[KIND_REQUEST], track.kind_seen[KIND_PROPOSE],
               track.kind_seen[KIND_EXECUTE], track.kind_seen[KIND_GIVE_UP],
               track.failures);
      if (track.failures == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
